>>> design/vt4_pkg.sv
// ----------------------------------------------------------------------------
// vt4_pkg: shared definitions for the 4x4 vertex transform
// Arithmetic widths, stream field layout, request codes and lane types.
// ----------------------------------------------------------------------------
package vt4_pkg;

  // Fixed-point format of matrix elements and vector components
  localparam int FRAC_BITS  = 16;
  localparam int ELEM_WIDTH = 32;

  // Width of each field as it travels on the stream
  localparam int FIELD_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;

  localparam int MAT_DIM   = 4;
  localparam int MAT_ELEMS = MAT_DIM * MAT_DIM;
  localparam int IDX_WIDTH = $clog2(MAT_ELEMS);

  // Lane arithmetic
  localparam int PROD_W  = 2 * ELEM_WIDTH;
  localparam int TRUNC_W = PROD_W - FRAC_BITS;
  localparam int SUM_W   = TRUNC_W + 2;

  // Input tdata layout, lowest bit up
  localparam int IN_IDX_LSB   = 0;
  localparam int IN_VALUE_LSB = IN_IDX_LSB + IDX_WIDTH;
  localparam int IN_VEC_LSB   = IN_VALUE_LSB + FIELD_WIDTH;
  localparam int IN_BITS      = IN_VEC_LSB + MAT_DIM * FIELD_WIDTH;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_TDATA_W = MAT_DIM * OUT_WIDTH;

  // Request codes carried in tuser
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_XFORM = 1'b1;

  // Element constants
  localparam logic [ELEM_WIDTH-1:0] ELEM_ONE = ELEM_WIDTH'(64'd1 << FRAC_BITS);
  localparam logic [ELEM_WIDTH-1:0] ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic [ELEM_WIDTH-1:0] ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  // Diagonal positions of the row-major matrix
  localparam logic [MAT_ELEMS-1:0] DIAG_MASK = 16'b1000_0100_0010_0001;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [MAT_DIM-1:0][ELEM_WIDTH-1:0] vt4_vec_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] value;
    logic                 sat;
  } vt4_lane_res_t;

  typedef struct packed {
    logic [MAT_DIM-1:0][OUT_WIDTH-1:0] comp;
    logic                              sat;
  } vt4_result_t;

endpackage

>>> design/vt4_lane.sv
// ----------------------------------------------------------------------------
// vt4_lane: one output component of the transform
// Multiplies the vector by one matrix column, truncates, sums and saturates.
// ----------------------------------------------------------------------------
module vt4_lane (
  input  logic                  clk_i,
  input  vt4_pkg::vt4_vec_t     vec_i,
  input  vt4_pkg::vt4_vec_t     col_i,
  output vt4_pkg::vt4_lane_res_t res_o
);

  logic signed [vt4_pkg::PROD_W-1:0]  prod_d [vt4_pkg::MAT_DIM];
  logic signed [vt4_pkg::PROD_W-1:0]  prod_q [vt4_pkg::MAT_DIM];
  logic signed [vt4_pkg::SUM_W-1:0]   sum;
  logic [vt4_pkg::SUM_W-vt4_pkg::ELEM_WIDTH:0] upper;
  logic                               over_pos;
  logic                               over_neg;
  logic [vt4_pkg::ELEM_WIDTH-1:0]     sat_val;
  vt4_pkg::vt4_lane_res_t             res_d;
  vt4_pkg::vt4_lane_res_t             res_q;

  // Stage 1: one product per term
  always_comb begin
    for (int i = 0; i < vt4_pkg::MAT_DIM; i++) begin
      prod_d[i] = $signed(vec_i[i]) * $signed(col_i[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < vt4_pkg::MAT_DIM; i++) begin
      prod_q[i] <= prod_d[i];
    end
  end

  // Stage 2: floor each product to the fixed-point grid, add, clamp
  always_comb begin
    sum = '0;
    for (int i = 0; i < vt4_pkg::MAT_DIM; i++) begin
      sum = sum + vt4_pkg::SUM_W'($signed(prod_q[i][vt4_pkg::PROD_W-1:vt4_pkg::FRAC_BITS]));
    end
    upper    = sum[vt4_pkg::SUM_W-1:vt4_pkg::ELEM_WIDTH-1];
    over_pos = !sum[vt4_pkg::SUM_W-1] && (|upper);
    over_neg = sum[vt4_pkg::SUM_W-1] && !(&upper);
    if (over_pos) begin
      sat_val = vt4_pkg::ELEM_MAX;
    end else if (over_neg) begin
      sat_val = vt4_pkg::ELEM_MIN;
    end else begin
      sat_val = sum[vt4_pkg::ELEM_WIDTH-1:0];
    end
    res_d.value = vt4_pkg::OUT_WIDTH'($signed(sat_val));
    res_d.sat   = over_pos || over_neg;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> design/vt4_merge.sv
// ----------------------------------------------------------------------------
// vt4_merge: combine lane results and queue them for the output stream
// ORs the lane overflow flags and holds results in a small queue.
// ----------------------------------------------------------------------------
module vt4_merge (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       push_i,
  input  vt4_pkg::vt4_lane_res_t [vt4_pkg::MAT_DIM-1:0] lane_i,
  input  logic                                       pop_i,
  output vt4_pkg::vt4_result_t                       head_o,
  output logic [vt4_pkg::CNT_W-1:0]                  count_o
);

  vt4_pkg::vt4_result_t              entry_q [vt4_pkg::FIFO_DEPTH];
  vt4_pkg::vt4_result_t              merged;
  logic [vt4_pkg::PTR_W-1:0]         wr_ptr_d, wr_ptr_q;
  logic [vt4_pkg::PTR_W-1:0]         rd_ptr_d, rd_ptr_q;
  logic [vt4_pkg::CNT_W-1:0]         count_d, count_q;
  logic                              do_pop;

  always_comb begin
    merged.sat = 1'b0;
    for (int j = 0; j < vt4_pkg::MAT_DIM; j++) begin
      merged.comp[j] = lane_i[j].value;
      merged.sat     = merged.sat | lane_i[j].sat;
    end
  end

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + vt4_pkg::CNT_W'(push_i) - vt4_pkg::CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= merged;
    end
  end

  assign head_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

>>> design/vertex_transform_4x4_top.sv
// ----------------------------------------------------------------------------
// vertex_transform_4x4_top: 4x4 matrix times vector in Q16.16
// Holds the matrix, streams vectors through four column lanes.
// ----------------------------------------------------------------------------
// The block keeps a 4x4 signed Q16.16 matrix, row-major, that is the identity
// after reset. A transfer with tuser = 0 loads one element and gives no result;
// a transfer with tuser = 1 carries a vector (x,y,z,w) and gives one result
// whose component j is sum_i v_i * M[i][j], each product floored to 16
// fractional bits and each sum clamped to 32 bits (result tuser flags a clamp).
// One item is accepted per clock while the input ready is high. A transform
// is registered first as the four 32x32 products of each lane, then as the
// truncate/add/clamp result, and is then written into the output queue. A load
// takes effect for the very next item. The input ready is issued from a credit
// count over the two lane stages and the 4-entry result queue, so it depends
// only on registers; with the output ready held high it never drops.

module vertex_transform_4x4_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // elem_index[3:0], elem_value[35:4], vec_x[67:36], vec_y[99:68],
  // vec_z[131:100], vec_w[163:132], zero[167:164]
  input  logic [vt4_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // req_type[0]
  input  logic                              s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
  output logic [vt4_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // saturated[0]
  output logic                              m_axis_tuser_o
);

  logic [vt4_pkg::MAT_ELEMS-1:0][vt4_pkg::ELEM_WIDTH-1:0] matrix_q;

  logic                                   in_xfer;
  logic                                   load_xfer;
  logic                                   xform_xfer;
  logic [vt4_pkg::IDX_WIDTH-1:0]          load_idx;
  logic [vt4_pkg::ELEM_WIDTH-1:0]         load_val;
  vt4_pkg::vt4_vec_t                      vec;
  vt4_pkg::vt4_vec_t                      lane_col [vt4_pkg::MAT_DIM];
  vt4_pkg::vt4_lane_res_t [vt4_pkg::MAT_DIM-1:0] lane_res;

  logic                                   v1_d, v1_q;
  logic                                   v2_d, v2_q;
  logic [vt4_pkg::CNT_W-1:0]              queue_cnt;
  logic [vt4_pkg::CNT_W-1:0]              occupancy;
  vt4_pkg::vt4_result_t                   head;

  // Credit: everything in the lanes plus the queue must leave room for one more
  assign occupancy = queue_cnt + vt4_pkg::CNT_W'(v1_q) + vt4_pkg::CNT_W'(v2_q);
  assign s_axis_tready_o = occupancy < vt4_pkg::CNT_W'(vt4_pkg::FIFO_DEPTH);

  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign load_xfer  = in_xfer && (s_axis_tuser_i == vt4_pkg::REQ_LOAD);
  assign xform_xfer = in_xfer && (s_axis_tuser_i == vt4_pkg::REQ_XFORM);

  // Unpack the input transfer; only the low element bits of each field count
  assign load_idx = s_axis_tdata_i[vt4_pkg::IN_IDX_LSB +: vt4_pkg::IDX_WIDTH];
  assign load_val = s_axis_tdata_i[vt4_pkg::IN_VALUE_LSB +: vt4_pkg::ELEM_WIDTH];

  always_comb begin
    for (int i = 0; i < vt4_pkg::MAT_DIM; i++) begin
      vec[i] = s_axis_tdata_i[vt4_pkg::IN_VEC_LSB + i * vt4_pkg::FIELD_WIDTH +:
                              vt4_pkg::ELEM_WIDTH];
    end
  end

  // Matrix store: written one element per load, reset to identity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vt4_pkg::MAT_ELEMS; i++) begin
        matrix_q[i] <= vt4_pkg::DIAG_MASK[i] ? vt4_pkg::ELEM_ONE : '0;
      end
    end else if (load_xfer) begin
      matrix_q[load_idx] <= load_val;
    end
  end

  // Route column j of the matrix to lane j
  always_comb begin
    for (int j = 0; j < vt4_pkg::MAT_DIM; j++) begin
      for (int i = 0; i < vt4_pkg::MAT_DIM; i++) begin
        lane_col[j][i] = matrix_q[i * vt4_pkg::MAT_DIM + j];
      end
    end
  end

  for (genvar j = 0; j < vt4_pkg::MAT_DIM; j++) begin : g_lane
    vt4_lane u_lane (
      .clk_i (clk_i),
      .vec_i (vec),
      .col_i (lane_col[j]),
      .res_o (lane_res[j])
    );
  end

  // Track which lane stages hold a live transform; loads never enter
  assign v1_d = xform_xfer;
  assign v2_d = v1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  vt4_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (v2_q),
    .lane_i  (lane_res),
    .pop_i   (m_axis_tready_i),
    .head_o  (head),
    .count_o (queue_cnt)
  );

  assign m_axis_tvalid_o = queue_cnt != '0;
  assign m_axis_tuser_o  = head.sat;

  always_comb begin
    for (int j = 0; j < vt4_pkg::MAT_DIM; j++) begin
      m_axis_tdata_o[j * vt4_pkg::OUT_WIDTH +: vt4_pkg::OUT_WIDTH] = head.comp[j];
    end
  end

  // Credits never let the lanes and queue overfill
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occupancy <= vt4_pkg::CNT_W'(vt4_pkg::FIFO_DEPTH))
    else $error("lane and queue occupancy exceeds queue depth");

  // A load must not start a result
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> !v1_q)
    else $error("load transfer entered the lane pipeline");

  // The matrix changes only on a load transfer
  a_matrix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !load_xfer |=> $stable(matrix_q))
    else $error("matrix changed without a load transfer");

  // The queue is never written while full and not draining
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (queue_cnt < vt4_pkg::CNT_W'(vt4_pkg::FIFO_DEPTH)) || m_axis_tready_i)
    else $error("result queue overflow");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the 4x4 vertex transform
// Loads matrix elements and streams vectors through the block, predicts each
// transformed vertex from a local copy of the matrix and checks every result
// in order, under four mixes of source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import vt4_pkg::*;

  localparam longint SUM_HI = 64'sd2147483647;
  localparam longint SUM_LO = -64'sd2147483648;

  // Tracks the matrix, predicts each vertex and checks what comes out
  class vertex_checker;
    logic [ELEM_WIDTH-1:0] matrix [MAT_ELEMS];
    vt4_result_t           pending_vertices [$];
    int loads, xforms, results, clamped, fails;

    function new();
      for (int k = 0; k < MAT_ELEMS; k++) matrix[k] = DIAG_MASK[k] ? ELEM_ONE : '0;
    endfunction

    // Apply a load to the matrix copy or queue the vertex a transform gives
    function void note_request(logic req, logic [3:0] idx, logic [31:0] value,
                               vt4_vec_t vec);
      vt4_result_t want;
      longint      acc;
      longint      prod;
      if (req == REQ_LOAD) begin
        matrix[idx] = value;
        loads++;
        return;
      end
      want.sat = 1'b0;
      for (int j = 0; j < MAT_DIM; j++) begin
        acc = 0;
        // each product floored to the fixed-point grid before the sum
        for (int i = 0; i < MAT_DIM; i++) begin
          prod = longint'(signed'(vec[i])) * longint'(signed'(matrix[i*MAT_DIM+j]));
          acc += prod >>> FRAC_BITS;
        end
        if (acc > SUM_HI) begin
          acc = SUM_HI;
          want.sat = 1'b1;
        end else if (acc < SUM_LO) begin
          acc = SUM_LO;
          want.sat = 1'b1;
        end
        want.comp[j] = acc[31:0];
      end
      if (want.sat) clamped++;
      xforms++;
      pending_vertices.push_back(want);
    endfunction

    function void check_vertex(logic [OUT_TDATA_W-1:0] data, logic sat);
      vt4_result_t want;
      logic        bad;
      results++;
      if (pending_vertices.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected vertex: x=%h y=%h z=%h w=%h sat=%b",
                   data[31:0], data[63:32], data[95:64], data[127:96], sat);
        return;
      end
      want = pending_vertices.pop_front();
      bad  = (sat !== want.sat);
      for (int j = 0; j < MAT_DIM; j++) bad |= (data[j*OUT_WIDTH +: OUT_WIDTH] !== want.comp[j]);
      if (bad) begin
        fails++;
        if (fails <= 10)
          $display("vertex %0d mismatch: expected x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
                   results, want.comp[0], want.comp[1], want.comp[2], want.comp[3], want.sat,
                   data[31:0], data[63:32], data[95:64], data[127:96], sat);
      end
    endfunction

    // Anything still queued after the drain never came out
    function void close_out();
      if (pending_vertices.size() != 0) begin
        fails += pending_vertices.size();
        $display("%0d expected vertices never arrived", pending_vertices.size());
      end
    endfunction
  endclass

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   m_tready = 1'b0;
  logic                   s_axis_tready_o;
  logic                   m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  int gap_pct   = 0;
  int stall_pct = 0;
  int phase_gap   [4] = '{0, 71, 0, 29};
  int phase_stall [4] = '{0, 0, 71, 29};

  vertex_checker vt_check;

  vertex_transform_4x4_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Sink back-pressure: drop ready with a chance of stall_pct percent
  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Outputs and ready are stable at the falling edge; a transfer seen here
  // completes at the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      vt_check.check_vertex(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Offer one item after a random gap and hold it until the block takes it.
  // Vector lanes are packed {w,z,y,x}.
  task automatic send_item(input logic req, input logic [3:0] idx,
                           input logic [31:0] value, input vt4_vec_t vec);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, vec, value, idx};
    do @(negedge clk_i); while (!s_axis_tready_o);
    vt_check.note_request(req, idx, value, vec);
    @(posedge clk_i);
  endtask

  // Mostly small Q16.16 values so that sums stay in range, with some full
  // random words and the corner values mixed in
  function automatic logic [31:0] pick_operand();
    logic [31:0] corners [6];
    corners = '{ELEM_MAX, ELEM_MIN, 32'h0, 32'hFFFF_FFFF, ELEM_ONE, -ELEM_ONE};
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return corners[$urandom_range(5)];
      default: return 32'($urandom_range(524288)) - 32'd262144;
    endcase
  endfunction

  function automatic vt4_vec_t pick_vector();
    vt4_vec_t v;
    for (int i = 0; i < MAT_DIM; i++) v[i] = pick_operand();
    return v;
  endfunction

  // Bursts of matrix updates followed by a run of vertices, with some
  // fully random items as noise
  task automatic run_random(input int budget);
    int sent;
    int n_load;
    int n_xf;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(99) < 75) begin
        n_load = ($urandom_range(3) == 0) ? MAT_ELEMS : $urandom_range(1, 6);
        for (int k = 0; k < n_load; k++) begin
          send_item(REQ_LOAD, (n_load == MAT_ELEMS) ? 4'(k) : 4'($urandom_range(15)),
                    pick_operand(), {$urandom, $urandom, $urandom, $urandom});
          sent++;
        end
        n_xf = $urandom_range(2, 12);
        for (int k = 0; k < n_xf; k++) begin
          send_item(REQ_XFORM, 4'($urandom), $urandom, pick_vector());
          sent++;
        end
      end else begin
        send_item(1'($urandom_range(1)), 4'($urandom), $urandom,
                  {$urandom, $urandom, $urandom, $urandom});
        sent++;
      end
    end
  endtask

  initial begin
    #(3_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    vt_check = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix: plain vector, extreme components, all-ones words
    send_item(REQ_XFORM, 4'h0, 32'h0,
              {32'h0000_8000, 32'hFFFD_0000, 32'h0002_0000, 32'h0001_0000});
    send_item(REQ_XFORM, 4'h0, 32'h0, {32'hFFFF_FFFF, 32'h0, ELEM_MIN, ELEM_MAX});
    send_item(REQ_XFORM, 4'hF, 32'hFFFF_FFFF,
              {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    // Extreme diagonal: clamp high and low in the same vertex
    send_item(REQ_LOAD, 4'd0, ELEM_MAX, '0);
    send_item(REQ_LOAD, 4'd5, ELEM_MIN, '0);
    send_item(REQ_LOAD, 4'd10, 32'hFFFF_FFFF, '0);
    send_item(REQ_LOAD, 4'd15, 32'h0, '0);
    send_item(REQ_XFORM, 4'h0, 32'h0, {ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX});
    send_item(REQ_XFORM, 4'h0, 32'h0, {ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN});
    // Negative product floors toward minus infinity: -1 ulp times 0.5
    send_item(REQ_LOAD, 4'd2, 32'h0000_8000, '0);
    send_item(REQ_XFORM, 4'h0, 32'h0, {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
    // Load ignores the vector lanes; transform ignores index and value
    send_item(REQ_LOAD, 4'd7, 32'h1234_5678,
              {32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    send_item(REQ_XFORM, 4'hA, 32'hDEAD_BEEF,
              {32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    // Four in-range terms whose sum overflows column 3
    send_item(REQ_LOAD, 4'd3, 32'h7FFF_0000, '0);
    send_item(REQ_LOAD, 4'd11, 32'h7FFF_0000, '0);
    send_item(REQ_LOAD, 4'd15, 32'h7FFF_0000, '0);
    send_item(REQ_XFORM, 4'h0, 32'h0,
              {32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    send_item(REQ_XFORM, 4'h0, 32'h0,
              {32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000});

    // Four pacing mixes: free flow, sparse source, heavy stall, both
    for (int p = 0; p < 4; p++) begin
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      run_random((p == 0) ? 155 : 175);
    end
    s_tvalid <= 1'b0;

    while (vt_check.pending_vertices.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    vt_check.close_out();

    $display("Sent %0d matrix loads and %0d vertices over four pacing mixes;",
             vt_check.loads, vt_check.xforms);
    $display("checked %0d results, %0d of them clamped, %0d mismatches.",
             vt_check.results, vt_check.clamped, vt_check.fails);
    if (vt_check.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
design/vt4_pkg.sv
design/vt4_lane.sv
design/vt4_merge.sv
design/vertex_transform_4x4_top.sv
tb/tb.sv
